// File: hw/rtl/mexp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, register indexes and the job word for the modexp block.
// ----------------------------------------------------------------------------
package mexp_pkg;
    localparam int VAL_W     = 63;
    localparam int EXP_W     = 16;
    localparam int EXP_BITS  = 16;
    localparam int BIT_IDX_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
    localparam int STEP_W    = $clog2(VAL_W);
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 1'b1;

    localparam logic [VAL_W-1:0] MODULUS_RESET  = 63'd3501765933723641651;
    localparam logic [EXP_W-1:0] EXPONENT_RESET = 16'd20771;

    typedef struct packed {
        logic             trivial;  // modulus of zero or one: answer is zero
        logic [VAL_W-1:0] base;
    } t_job;
endpackage

// File: hw/rtl/mexp_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp channel interfaces
// Valid/ready channels for the base words in and the result words out.
// ----------------------------------------------------------------------------
interface mexp_base_if import mexp_pkg::*;;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] base;
    modport source (output valid, output base, input ready);
    modport sink   (input valid, input base, output ready);
endinterface

interface mexp_pm_if import mexp_pkg::*;;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] power_mod;
    modport source (output valid, output power_mod, input ready);
    modport sink   (input valid, input power_mod, output ready);
endinterface

// File: hw/rtl/mexp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_front
// Register incoming base words and tag trivial moduli.
// ----------------------------------------------------------------------------
module mexp_front import mexp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [VAL_W-1:0] i_base,
    input  logic [VAL_W-1:0] i_modulus,
    output logic             o_valid,
    output t_job             o_job,
    input  logic             i_ready
);
    logic r_valid;
    t_job r_job;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_job.base    <= i_base;
            r_job.trivial <= (i_modulus[VAL_W-1:1] == '0);
        end
    end
endmodule

// File: hw/rtl/mexp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_queue
// Two-entry job queue between front and engine.
// ----------------------------------------------------------------------------
module mexp_queue import mexp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    output t_job o_job,
    input  logic i_ready
);
    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) r_mem[r_wp] <= i_job;
    end
endmodule

// File: hw/rtl/mexp_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_engine
// Square-and-multiply with a bit-serial shift-and-add modular multiplier.
// ----------------------------------------------------------------------------
module mexp_engine import mexp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [VAL_W-1:0] i_modulus,
    input  logic [EXP_W-1:0] i_exponent,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_job             i_job,
    output logic             o_valid,
    output logic [VAL_W-1:0] o_data,
    input  logic             i_ready
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_WAIT = 3'b100
    } t_state;

    t_state                r_state;
    logic [VAL_W-1:0]      r_acc, r_r, r_a, r_y, r_base;
    logic [STEP_W-1:0]     r_cnt;
    logic [BIT_IDX_W-1:0]  r_bit;
    logic                  r_ph_mul;
    logic                  r_out_valid;
    logic [VAL_W-1:0]      r_out_data;

    logic [VAL_W:0] n, t1, t2, t3, t4;
    logic           last_step, exp_bit, load_out;

    assign n  = {1'b0, i_modulus};
    assign t1 = {r_r, 1'b0};
    assign t2 = (t1 >= n) ? t1 - n : t1;
    assign t3 = r_y[VAL_W-1] ? t2 + {1'b0, r_a} : t2;
    assign t4 = (t3 >= n) ? t3 - n : t3;

    assign last_step = (r_cnt == STEP_W'(VAL_W - 1));
    assign exp_bit   = (int'(r_bit) < EXP_W) ? i_exponent[r_bit] : 1'b0;
    assign load_out  = (r_state == S_WAIT) && (!r_out_valid || i_ready);

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) r_state <= i_job.trivial ? S_WAIT : S_MUL;
                end
                S_MUL: begin
                    if (last_step && !(!r_ph_mul && exp_bit) && r_bit == '0) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (load_out) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end

        if (load_out) r_out_data <= r_acc;

        case (r_state)
            S_IDLE: begin
                // start with a squaring of acc = 1
                r_base   <= i_job.base;
                r_acc    <= i_job.trivial ? '0 : VAL_W'(1);
                r_a      <= VAL_W'(1);
                r_y      <= VAL_W'(1);
                r_r      <= '0;
                r_cnt    <= '0;
                r_bit    <= BIT_IDX_W'(EXP_BITS - 1);
                r_ph_mul <= 1'b0;
            end
            S_MUL: begin
                r_r   <= t4[VAL_W-1:0];
                r_y   <= {r_y[VAL_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (last_step) begin
                    r_acc <= t4[VAL_W-1:0];
                    r_a   <= t4[VAL_W-1:0];
                    r_r   <= '0;
                    r_cnt <= '0;
                    if (!r_ph_mul && exp_bit) begin
                        // scan the raw base so it is reduced on the way
                        r_ph_mul <= 1'b1;
                        r_y      <= r_base;
                    end else begin
                        r_ph_mul <= 1'b0;
                        r_y      <= t4[VAL_W-1:0];
                        r_bit    <= r_bit - 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    a_partial_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_r < i_modulus))
        else $error("partial remainder not reduced");
    a_addend_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_a < i_modulus))
        else $error("addend not reduced");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_cnt < STEP_W'(VAL_W)))
        else $error("step counter out of range");
    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> r_out_valid)
        else $error("result load lost");
endmodule

// File: hw/rtl/modular_exponentiation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation
// Left-to-right square-and-multiply: power_mod = base ** exponent mod modulus.
// ----------------------------------------------------------------------------
// Each base word returns one result word. The front stage registers the base
// and tags moduli of zero or one (answer zero); a two-entry queue decouples it
// from the engine, so new words are taken while a job runs or a result waits.
// The engine does one modular multiply per squaring and per set exponent bit,
// each as 63 shift-and-add steps (one step per cycle on the shared adder and
// compare chain). Write modulus and exponent only while the block is idle.
module modular_exponentiation import mexp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mexp_base_if.sink            s_in,
    mexp_pm_if.source            m_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [VAL_W-1:0]     i_cfg_data
);
    logic [VAL_W-1:0] r_modulus;
    logic [EXP_W-1:0] r_exponent;

    logic f_valid, f_ready, q_valid, q_ready;
    t_job f_job, q_job;

    // hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= MODULUS_RESET;
            r_exponent <= EXPONENT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODULUS:  r_modulus  <= i_cfg_data;
                CFG_EXPONENT: r_exponent <= i_cfg_data[EXP_W-1:0];
                default: ;
            endcase
        end
    end

    mexp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_in.valid),
        .o_ready   (s_in.ready),
        .i_base    (s_in.base),
        .i_modulus (r_modulus),
        .o_valid   (f_valid),
        .o_job     (f_job),
        .i_ready   (f_ready)
    );

    mexp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_job   (f_job),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_ready (q_ready)
    );

    mexp_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_modulus  (r_modulus),
        .i_exponent (r_exponent),
        .i_valid    (q_valid),
        .o_ready    (q_ready),
        .i_job      (q_job),
        .o_valid    (m_out.valid),
        .o_data     (m_out.power_mod),
        .i_ready    (m_out.ready)
    );
endmodule
